// File: hw/rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and constants of the modular exponentiation core: register
// indexes, multiplier operation codes, controller state encoding and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mexp_pkg;

	// fixed field widths
	localparam int unsigned BASE_W    = 32;
	localparam int unsigned RESULT_W  = 32;
	localparam int unsigned CFG_W     = 32;
	localparam int unsigned CFG_IDX_W = 8;

	// one multiplier pass walks every bit of its b operand
	localparam int unsigned MUL_STEPS = BASE_W;
	localparam int unsigned MUL_CNT_W = $clog2(MUL_STEPS);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = CFG_IDX_W'(1);

	// what a multiplier pass computes and where its product goes
	typedef enum logic [1:0] {
		MUL_REDUCE = 2'd0, // sq  = base * 1 mod m
		MUL_ACC    = 2'd1, // acc = acc * sq mod m
		MUL_SQR    = 2'd2  // sq  = sq * sq mod m
	} mul_op_t;

	// controller states
	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_REDUCE   = 7'b0000010,
		S_RED_WAIT = 7'b0000100,
		S_BIT      = 7'b0001000,
		S_ACC_WAIT = 7'b0010000,
		S_SQR_WAIT = 7'b0100000,
		S_FINISH   = 7'b1000000
	} mexp_state_t;

	// controller to datapath
	typedef struct packed {
		logic    load;      // capture base, exponent, init accumulator
		logic    mul_start; // launch a multiplier pass
		mul_op_t mul_op;    // operation of that pass
		logic    shift_exp; // drop the exponent lsb
		logic    out_load;  // move accumulator to the output register
	} mexp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic mod_zero; // modulus register is zero
		logic exp_zero; // no exponent bits left
		logic exp_lsb;  // current exponent bit
		logic mul_busy; // multiplier pass running
		logic mul_done; // multiplier pass finished, product written
		logic out_free; // output register can take a new item
	} mexp_stat_t;

endpackage

// File: hw/rtl/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial interleaved modular multiplier: a * b mod m, one bit of b per
// cycle, msb first, with two conditional subtractions per step.
// ----------------------------------------------------------------------------
module mexp_mulmod #(
	parameter int unsigned W = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [W-1:0]                 a,
	input  logic [mexp_pkg::BASE_W-1:0]  b,
	input  logic [W-1:0]                 m,
	output logic                         busy,
	output logic                         done,
	output logic [W-1:0]                 product
);
	import mexp_pkg::*;

	localparam logic [MUL_CNT_W-1:0] CNT_LAST = MUL_CNT_W'(MUL_STEPS - 1);

	logic [W-1:0]         r_q;
	logic [W-1:0]         a_q;
	logic [BASE_W-1:0]    b_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [W:0] m_ext;
	logic [W:0] dbl;
	logic [W:0] dbl_red;
	logic [W:0] sum;
	logic [W:0] sum_red;

	// one step: r = 2r mod m, then r = r + a*bit mod m
	always_comb begin
		m_ext   = {1'b0, m};
		dbl     = {r_q, 1'b0};
		dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
		sum     = dbl_red + (b_q[BASE_W-1] ? {1'b0, a_q} : '0);
		sum_red = (sum >= m_ext) ? sum - m_ext : sum;
	end

	// step counter and handshake to the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_LAST;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand and partial remainder registers
	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			a_q <= a;
			b_q <= b;
		end else if (busy_q) begin
			r_q <= sum_red[W-1:0];
			b_q <= {b_q[BASE_W-2:0], 1'b0};
		end
	end

	assign busy    = busy_q;
	assign done    = done_q;
	assign product = r_q;

	// a pass ends only after it ran
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("mulmod done without a running pass");

	// a launched pass is running in the next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("mulmod start did not raise busy");

endmodule

// File: hw/rtl/mexp_datapath.sv
// ----------------------------------------------------------------------------
// mexp_datapath
// Configuration registers, exponent shift register, accumulator and running
// square, the shared modular multiplier and the output register.
// ----------------------------------------------------------------------------
module mexp_datapath #(
	parameter int unsigned MOD_WIDTH = 32,
	parameter int unsigned EXP_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [mexp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mexp_pkg::CFG_W-1:0]      cfg_data,
	input  logic [mexp_pkg::BASE_W-1:0]     base_value,
	input  logic                            out_stall,
	output logic                            out_valid,
	output logic [mexp_pkg::RESULT_W-1:0]   result,
	input  mexp_pkg::mexp_cmd_t             cmd,
	output mexp_pkg::mexp_stat_t            stat
);
	import mexp_pkg::*;

	// the exponent register is never wider than its 32-bit port
	localparam int unsigned EXP_BITS = (EXP_WIDTH < CFG_W) ? EXP_WIDTH : CFG_W;

	logic [EXP_BITS-1:0]  exp_cfg_q;
	logic [MOD_WIDTH-1:0] mod_cfg_q;
	logic [EXP_BITS-1:0]  exp_q;
	logic [BASE_W-1:0]    base_q;
	logic [MOD_WIDTH-1:0] acc_q;
	logic [MOD_WIDTH-1:0] sq_q;
	mul_op_t              op_q;
	logic [RESULT_W-1:0]  result_q;
	logic                 out_valid_q;

	logic [MOD_WIDTH-1:0] mul_a;
	logic [BASE_W-1:0]    mul_b;
	logic                 mul_busy;
	logic                 mul_done;
	logic [MOD_WIDTH-1:0] mul_p;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_cfg_q <= '0;
			mod_cfg_q <= MOD_WIDTH'(1);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_EXPONENT: exp_cfg_q <= cfg_data[EXP_BITS-1:0];
				REG_MODULUS:  mod_cfg_q <= cfg_data[MOD_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// multiplier operand select
	always_comb begin
		case (cmd.mul_op)
			MUL_REDUCE: begin
				mul_a = MOD_WIDTH'(1);
				mul_b = base_q;
			end
			MUL_ACC: begin
				mul_a = acc_q;
				mul_b = BASE_W'(sq_q);
			end
			default: begin
				mul_a = sq_q;
				mul_b = BASE_W'(sq_q);
			end
		endcase
	end

	mexp_mulmod #(
		.W(MOD_WIDTH)
	) u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.m       (mod_cfg_q),
		.busy    (mul_busy),
		.done    (mul_done),
		.product (mul_p)
	);

	// working registers: exponent bits, accumulator, running square
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q <= base_value;
			exp_q  <= exp_cfg_q;
			// 1 mod m, and 0 for the zero-modulus guard
			acc_q  <= (mod_cfg_q > MOD_WIDTH'(1)) ? MOD_WIDTH'(1) : '0;
		end else if (cmd.shift_exp) begin
			exp_q <= exp_q >> 1;
		end
		if (cmd.mul_start) begin
			op_q <= cmd.mul_op;
		end
		if (mul_done) begin
			if (op_q == MUL_ACC) begin
				acc_q <= mul_p;
			end else begin
				sq_q <= mul_p;
			end
		end
	end

	// output register, parts the result from the next item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_q <= RESULT_W'(acc_q);
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

	always_comb begin
		stat.mod_zero = (mod_cfg_q == '0);
		stat.exp_zero = (exp_q == '0);
		stat.exp_lsb  = exp_q[0];
		stat.mul_busy = mul_busy;
		stat.mul_done = mul_done;
		stat.out_free = !out_valid_q || !out_stall;
	end

	// a waiting result is never overwritten
	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && out_stall))
		else $error("output register overwritten while stalled");

endmodule

// File: hw/rtl/mexp_ctrl.sv
// ----------------------------------------------------------------------------
// mexp_ctrl
// Sequencer of the square-and-multiply loop: base reduction, then for each
// exponent bit an optional accumulate pass and a square pass.
// ----------------------------------------------------------------------------
module mexp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  mexp_pkg::mexp_stat_t  stat,
	output mexp_pkg::mexp_cmd_t   cmd
);
	import mexp_pkg::*;

	mexp_state_t state_q;
	mexp_state_t state_d;

	// next state and commands
	always_comb begin
		state_d       = state_q;
		cmd.load      = 1'b0;
		cmd.mul_start = 1'b0;
		cmd.mul_op    = MUL_REDUCE;
		cmd.shift_exp = 1'b0;
		cmd.out_load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_REDUCE;
				end
			end
			S_REDUCE: begin
				if (stat.mod_zero) begin
					state_d = S_FINISH;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mul_op    = MUL_REDUCE;
					state_d       = S_RED_WAIT;
				end
			end
			S_RED_WAIT: begin
				if (stat.mul_done) begin
					state_d = S_BIT;
				end
			end
			S_BIT: begin
				if (stat.exp_zero) begin
					state_d = S_FINISH;
				end else if (stat.exp_lsb) begin
					cmd.mul_start = 1'b1;
					cmd.mul_op    = MUL_ACC;
					state_d       = S_ACC_WAIT;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mul_op    = MUL_SQR;
					cmd.shift_exp = 1'b1;
					state_d       = S_SQR_WAIT;
				end
			end
			S_ACC_WAIT: begin
				if (stat.mul_done) begin
					cmd.mul_start = 1'b1;
					cmd.mul_op    = MUL_SQR;
					cmd.shift_exp = 1'b1;
					state_d       = S_SQR_WAIT;
				end
			end
			S_SQR_WAIT: begin
				if (stat.mul_done) begin
					state_d = S_BIT;
				end
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	// a pass is launched only on an idle multiplier
	a_start_idle_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_start |-> !stat.mul_busy)
		else $error("multiplier started while busy");

	// a finished product is only ever awaited in a wait state
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		stat.mul_done |-> (state_q == S_RED_WAIT || state_q == S_ACC_WAIT ||
			state_q == S_SQR_WAIT))
		else $error("multiplier product arrived outside a wait state");

endmodule

// File: hw/rtl/modular_exponentiation_core.sv
// Time from accept to result grows with each exponent bit up to the highest set one, and
// more with each set bit; a zero modulus skips the loop. The bit-serial multiplier sets the
// pace, and a stalled result can block the output.
// One item at a time: the next item is taken the cycle after the result enters the output
// register, which holds it while the consumer stalls.
// Reset (asynchronous, active low): exponent 0, modulus 1, no item in flight.
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// Right-to-left binary square-and-multiply: result = base^exponent mod
// modulus, with exponent and modulus held in configuration registers.
// ----------------------------------------------------------------------------
module modular_exponentiation_core #(
	parameter int unsigned MOD_WIDTH = 32,
	parameter int unsigned EXP_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_wr_en,
	input  logic [mexp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mexp_pkg::CFG_W-1:0]      cfg_data,
	// input item channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [mexp_pkg::BASE_W-1:0]     base_value,
	// result item channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [mexp_pkg::RESULT_W-1:0]   result
);
	import mexp_pkg::*;

	mexp_cmd_t  cmd;
	mexp_stat_t stat;

	// loop sequencer
	mexp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// registers and modular multiplier
	mexp_datapath #(
		.MOD_WIDTH (MOD_WIDTH),
		.EXP_WIDTH (EXP_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.base_value (base_value),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.result     (result),
		.cmd        (cmd),
		.stat       (stat)
	);

endmodule
